// File: rtl/core/pdbf_pkg.sv
// Package for the peridynamic bond force block: payload types, register codes,
// saturation limits and the saturating shift used after every pdbf_mul product.
// No dependencies.
`default_nettype none

package pdbf_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BULK_MODULUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STRETCH  = 1'b1;

    localparam logic [31:0] BULK_MODULUS_RST = 32'h0001_0000;
    localparam logic [31:0] MAX_STRETCH_RST  = 32'h0001_0000;

    localparam logic [63:0] SAT_LIM   = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_E48   = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_POS47 = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG47 = 64'h0000_8000_0000_0000;

    // 1.0 in Q16.16 shifted up once more: the dividend of 2^32 / v.
    localparam logic [32:0] INV_DIVIDEND = 33'h1_0000_0000;

    typedef struct packed {
        logic signed [31:0] sep_x;
        logic signed [31:0] sep_y;
        logic signed [31:0] sep_z;
        logic [30:0]        rest_length;
        logic [31:0]        inter_volume_i;
        logic [31:0]        inter_volume_j;
        logic [31:0]        vol_fraction_i;
        logic [31:0]        vol_fraction_j;
    } t_bond_in;

    typedef struct packed {
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic [47:0]        bond_energy;
        logic               bond_broken;
    } t_bond_out;

    function automatic logic [63:0] f_sat_shr(input logic [127:0] prod,
                                              input int unsigned shamt,
                                              input logic [63:0] limit);
        logic [127:0] shifted;
        shifted = prod >> shamt;
        f_sat_shr = (shifted > {64'd0, limit}) ? limit : shifted[63:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pdbf_mul.sv
// Two-stage 64 x 64 unsigned multiplier built from four 32 x 32 partial products.
// No package dependencies.
`default_nettype none

module pdbf_mul (
    input  logic         i_clk,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic [127:0] o_p
);

    logic [63:0]  r_p00;
    logic [63:0]  r_p01;
    logic [63:0]  r_p10;
    logic [63:0]  r_p11;
    logic [127:0] r_sum;

    always_ff @(posedge i_clk) begin
        r_p00 <= 64'(i_a[31:0])  * 64'(i_b[31:0]);
        r_p01 <= 64'(i_a[31:0])  * 64'(i_b[63:32]);
        r_p10 <= 64'(i_a[63:32]) * 64'(i_b[31:0]);
        r_p11 <= 64'(i_a[63:32]) * 64'(i_b[63:32]);
        r_sum <= {64'd0, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
               + {r_p11, 64'd0};
    end

    assign o_p = r_sum;

endmodule

`default_nettype wire

// File: rtl/core/pdbf_sqrt.sv
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// No package dependencies.
`default_nettype none

module pdbf_sqrt (
    input  logic        i_clk,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    localparam int STEPS = 32;

    logic [33:0] r_rem  [1:STEPS];
    logic [31:0] r_root [1:STEPS];
    logic [63:0] r_rad  [1:STEPS];

    logic [33:0] n_rem  [1:STEPS];
    logic [31:0] n_root [1:STEPS];
    logic [63:0] n_rad  [1:STEPS];

    always_comb begin
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
        logic [35:0] t;
        logic [35:0] trial;
        logic [35:0] diff;
        for (int k = 1; k <= STEPS; k++) begin
            if (k == 1) begin
                rem  = '0;
                root = '0;
                rad  = i_rad;
            end else begin
                rem  = r_rem[k-1];
                root = r_root[k-1];
                rad  = r_rad[k-1];
            end
            t     = {rem, rad[63:62]};
            trial = {2'b00, root, 2'b01};
            diff  = t - trial;
            if (t >= trial) begin
                n_rem[k]  = diff[33:0];
                n_root[k] = {root[30:0], 1'b1};
            end else begin
                n_rem[k]  = t[33:0];
                n_root[k] = {root[30:0], 1'b0};
            end
            n_rad[k] = {rad[61:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= STEPS; k++) begin
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
            r_rad[k]  <= n_rad[k];
        end
    end

    assign o_root = r_root[STEPS];

endmodule

`default_nettype wire

// File: rtl/core/peridynamic_bond_force.sv
// Top level of the peridynamic bond force pipeline (PMB bond, maximum stretch rule).
// Depends on pdbf_pkg, pdbf_mul and pdbf_sqrt.
//
// Usage: a bond is transferred in at a rising edge where start is high and busy is
// low. busy is always low, so a bond may be offered in every cycle. Each bond gives
// exactly one result on o_result, marked by o_strobe for one cycle.
// Throughput is one bond per cycle. The latency is set by the chain of
// one-bit-per-stage units: 32 square root stages, 49 stretch division stages,
// the product chain and 62 force division stages.
// The receiver cannot stall; results leave in input order.
// Configuration writes go through i_cfg_we, i_cfg_idx and i_cfg_data and take effect
// at once; the user must make them while no bond is in flight (not enforced).
// Reset clears the pipeline valid bits and returns bulk_modulus and max_stretch to 1.0.
// No result is lost or invented by reset beyond dropping bonds in flight.
`default_nettype none

module peridynamic_bond_force (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  pdbf_pkg::t_bond_in                  i_bond,
    output logic                                o_strobe,
    output pdbf_pkg::t_bond_out                 o_result,
    input  logic                                i_cfg_we,
    input  logic [pdbf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pdbf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import pdbf_pkg::*;

    localparam int S_INV  = 33;
    localparam int S_ROOT = 34;
    localparam int S_ST0  = 35;
    localparam int S_C    = 37;
    localparam int S_CW   = 40;
    localparam int S_U    = 52;
    localparam int S_AS   = 84;
    localparam int S_BRK  = 85;
    localparam int S_FM   = 87;
    localparam int S_FB0  = 88;
    localparam int S_EN   = 90;
    localparam int S_FB   = 150;
    localparam int S_MAG  = 153;
    localparam int S_OUT  = 154;

    logic              w_accept;
    logic [S_OUT:0]    r_vld;
    logic [31:0]       r_bulk_modulus;
    logic [31:0]       r_max_stretch;

    logic [2:0][31:0]  w_sep;
    logic [2:0]        r_sgn_d  [0:S_MAG-1];
    logic [2:0][31:0]  r_m_d    [0:S_ROOT];
    logic [30:0]       r_r0_d   [0:S_FB-1];
    logic [1:0][31:0]  r_v_d    [0:S_INV-1];
    logic [1:0][31:0]  r_vf;
    logic [2:0][63:0]  r_sq;
    logic [47:0]       r_w_d    [1:S_C];
    logic [63:0]       r_rsq;
    logic [31:0]       w_root;

    logic [1:0][32:0]  r_inv_qd  [0:S_INV];
    logic [1:0][31:0]  r_inv_rem [0:S_INV];
    logic [1:0][32:0]  n_inv_qd  [1:S_INV];
    logic [1:0][31:0]  n_inv_rem [1:S_INV];
    logic [33:0]       r_invsum;

    logic [35:0]       w_k9;
    logic [127:0]      w_p_c;
    logic [61:0]       r_c;
    logic [127:0]      w_p_cw;
    logic [61:0]       r_cw_d   [S_CW:S_FM];

    logic [33:0]       w_dr;
    logic [32:0]       w_adr;
    logic [48:0]       r_st_qd  [S_ST0:S_AS];
    logic [30:0]       r_st_rem [S_ST0:S_AS];
    logic [48:0]       n_st_qd  [S_ST0+1:S_AS];
    logic [30:0]       n_st_rem [S_ST0+1:S_AS];
    logic              r_drn_d  [S_ST0:S_AS];

    logic [31:0]       r_r_d    [S_ST0:S_U-1];
    logic              r_rz_d   [S_ST0:S_MAG];
    logic [2:0][16:0]  r_u_qd   [S_ST0:S_U];
    logic [2:0][31:0]  r_u_rem  [S_ST0:S_U];
    logic [2:0][16:0]  n_u_qd   [S_ST0+1:S_U];
    logic [2:0][31:0]  n_u_rem  [S_ST0+1:S_U];
    logic [2:0][16:0]  r_u_d    [S_U+1:S_FB];

    logic [48:0]       w_as;
    logic              w_sneg;
    logic [49:0]       w_s;
    logic              r_brk_d  [S_BRK:S_MAG];
    logic              r_sneg_d [S_BRK:S_MAG-1];

    logic [127:0]      w_p_s2;
    logic [61:0]       r_s2;
    logic [127:0]      w_p_fm;
    logic [61:0]       r_fm;
    logic [127:0]      w_p_en;
    logic [47:0]       r_en_d   [S_EN:S_MAG];

    logic [61:0]       r_fb_qd  [S_FB0:S_FB];
    logic [30:0]       r_fb_rem [S_FB0:S_FB];
    logic [61:0]       n_fb_qd  [S_FB0+1:S_FB];
    logic [30:0]       n_fb_rem [S_FB0+1:S_FB];
    logic              r_fb_sat [S_FB0:S_FB];
    logic [61:0]       w_fb;

    logic [2:0][127:0] w_p_f;
    logic [2:0][47:0]  r_mag;
    logic [2:0]        r_neg;
    logic [2:0][47:0]  w_force;
    t_bond_out         r_result;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    assign w_sep[0] = i_bond.sep_x;
    assign w_sep[1] = i_bond.sep_y;
    assign w_sep[2] = i_bond.sep_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld          <= '0;
            r_bulk_modulus <= BULK_MODULUS_RST;
            r_max_stretch  <= MAX_STRETCH_RST;
        end else begin
            r_vld <= {r_vld[S_OUT-1:0], w_accept};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BULK_MODULUS: r_bulk_modulus <= i_cfg_data;
                    CFG_MAX_STRETCH:  r_max_stretch  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Front end: magnitudes, squares and the squared length.
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_sgn_d[0][a] <= w_sep[a][31];
            r_m_d[0][a]   <= w_sep[a][31] ? (32'd0 - w_sep[a]) : w_sep[a];
            r_sq[a]       <= 64'(r_m_d[0][a]) * 64'(r_m_d[0][a]);
        end
        r_r0_d[0]  <= (i_bond.rest_length == '0) ? 31'd1 : i_bond.rest_length;
        r_v_d[0][0] <= (i_bond.inter_volume_i == '0) ? 32'd1 : i_bond.inter_volume_i;
        r_v_d[0][1] <= (i_bond.inter_volume_j == '0) ? 32'd1 : i_bond.inter_volume_j;
        r_vf[0]    <= i_bond.vol_fraction_i;
        r_vf[1]    <= i_bond.vol_fraction_j;
        r_w_d[1]   <= 48'((64'(r_vf[0]) * 64'(r_vf[1])) >> 16);
        r_rsq      <= r_sq[0] + r_sq[1] + r_sq[2];

        for (int k = 1; k < S_MAG; k++) r_sgn_d[k] <= r_sgn_d[k-1];
        for (int k = 1; k <= S_ROOT; k++) r_m_d[k] <= r_m_d[k-1];
        for (int k = 1; k < S_FB; k++) r_r0_d[k] <= r_r0_d[k-1];
        for (int k = 1; k < S_INV; k++) r_v_d[k] <= r_v_d[k-1];
        for (int k = 2; k <= S_C; k++) r_w_d[k] <= r_w_d[k-1];
    end

    pdbf_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r_rsq),
        .o_root (w_root)
    );

    // Reciprocal volumes 2^32 / v, one quotient bit per stage.
    always_comb begin
        logic [32:0] t;
        logic [32:0] d;
        logic [32:0] diff;
        for (int k = 1; k <= S_INV; k++) begin
            for (int l = 0; l < 2; l++) begin
                t    = {r_inv_rem[k-1][l], r_inv_qd[k-1][l][32]};
                d    = {1'b0, r_v_d[k-1][l]};
                diff = t - d;
                if (t >= d) begin
                    n_inv_rem[k][l] = diff[31:0];
                    n_inv_qd[k][l]  = {r_inv_qd[k-1][l][31:0], 1'b1};
                end else begin
                    n_inv_rem[k][l] = t[31:0];
                    n_inv_qd[k][l]  = {r_inv_qd[k-1][l][31:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_inv_qd[0]  <= {INV_DIVIDEND, INV_DIVIDEND};
        r_inv_rem[0] <= '0;
        for (int k = 1; k <= S_INV; k++) begin
            r_inv_qd[k]  <= n_inv_qd[k];
            r_inv_rem[k] <= n_inv_rem[k];
        end
        r_invsum <= {1'b0, r_inv_qd[S_INV][0]} + {1'b0, r_inv_qd[S_INV][1]};
    end

    // Micromodulus and its product with the volume fractions.
    assign w_k9 = {r_bulk_modulus, 3'b000} + 36'(r_bulk_modulus);

    pdbf_mul u_mul_c (
        .i_clk (i_clk),
        .i_a   (64'(w_k9)),
        .i_b   (64'(r_invsum)),
        .o_p   (w_p_c)
    );

    pdbf_mul u_mul_cw (
        .i_clk (i_clk),
        .i_a   (64'(r_c)),
        .i_b   (64'(r_w_d[S_C])),
        .o_p   (w_p_cw)
    );

    always_ff @(posedge i_clk) begin
        r_c         <= 62'(f_sat_shr(w_p_c, 16, SAT_LIM));
        r_cw_d[S_CW] <= 62'(f_sat_shr(w_p_cw, 16, SAT_LIM));
        for (int k = S_CW + 1; k <= S_FM; k++) r_cw_d[k] <= r_cw_d[k-1];
    end

    // Stretch magnitude floor(|r - r0| * 2^16 / r0).
    assign w_dr  = {2'b00, w_root} - {3'b000, r_r0_d[S_ROOT]};
    assign w_adr = w_dr[33] ? 33'(34'd0 - w_dr) : w_dr[32:0];

    always_comb begin
        logic [31:0] t;
        logic [31:0] d;
        logic [31:0] diff;
        for (int k = S_ST0 + 1; k <= S_AS; k++) begin
            t    = {r_st_rem[k-1], r_st_qd[k-1][48]};
            d    = {1'b0, r_r0_d[k-1]};
            diff = t - d;
            if (t >= d) begin
                n_st_rem[k] = diff[30:0];
                n_st_qd[k]  = {r_st_qd[k-1][47:0], 1'b1};
            end else begin
                n_st_rem[k] = t[30:0];
                n_st_qd[k]  = {r_st_qd[k-1][47:0], 1'b0};
            end
        end
    end

    // Direction cosines floor(|sep| * 2^16 / r); for nonzero r the quotient never exceeds 1.0.
    always_comb begin
        logic [32:0] t;
        logic [32:0] d;
        logic [32:0] diff;
        for (int k = S_ST0 + 1; k <= S_U; k++) begin
            for (int a = 0; a < 3; a++) begin
                t    = {r_u_rem[k-1][a], r_u_qd[k-1][a][16]};
                d    = {1'b0, r_r_d[k-1]};
                diff = t - d;
                if (t >= d) begin
                    n_u_rem[k][a] = diff[31:0];
                    n_u_qd[k][a]  = {r_u_qd[k-1][a][15:0], 1'b1};
                end else begin
                    n_u_rem[k][a] = t[31:0];
                    n_u_qd[k][a]  = {r_u_qd[k-1][a][15:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_st_qd[S_ST0]  <= {w_adr, 16'd0};
        r_st_rem[S_ST0] <= '0;
        r_drn_d[S_ST0]  <= w_dr[33];
        r_r_d[S_ST0]    <= w_root;
        r_rz_d[S_ST0]   <= (w_root == '0);
        for (int a = 0; a < 3; a++) begin
            r_u_qd[S_ST0][a]  <= {r_m_d[S_ROOT][a][0], 16'd0};
            r_u_rem[S_ST0][a] <= {1'b0, r_m_d[S_ROOT][a][31:1]};
        end
        for (int k = S_ST0 + 1; k <= S_AS; k++) begin
            r_st_qd[k]  <= n_st_qd[k];
            r_st_rem[k] <= n_st_rem[k];
            r_drn_d[k]  <= r_drn_d[k-1];
        end
        for (int k = S_ST0 + 1; k <= S_U; k++) begin
            r_u_qd[k]  <= n_u_qd[k];
            r_u_rem[k] <= n_u_rem[k];
        end
        for (int k = S_ST0 + 1; k < S_U; k++) r_r_d[k] <= r_r_d[k-1];
        for (int k = S_ST0 + 1; k <= S_MAG; k++) r_rz_d[k] <= r_rz_d[k-1];
        r_u_d[S_U+1] <= r_u_qd[S_U];
        for (int k = S_U + 2; k <= S_FB; k++) r_u_d[k] <= r_u_d[k-1];
    end

    // Signed stretch, failure flag, and the products that use it.
    assign w_as   = r_st_qd[S_AS];
    assign w_sneg = r_drn_d[S_AS] & (w_as != '0);
    assign w_s    = w_sneg ? (50'd0 - {1'b0, w_as}) : {1'b0, w_as};

    pdbf_mul u_mul_s2 (
        .i_clk (i_clk),
        .i_a   (64'(w_as)),
        .i_b   (64'(w_as)),
        .o_p   (w_p_s2)
    );

    pdbf_mul u_mul_fm (
        .i_clk (i_clk),
        .i_a   (64'(r_cw_d[S_AS])),
        .i_b   (64'(w_as)),
        .o_p   (w_p_fm)
    );

    pdbf_mul u_mul_en (
        .i_clk (i_clk),
        .i_a   (64'(r_cw_d[S_FM])),
        .i_b   (64'(r_s2)),
        .o_p   (w_p_en)
    );

    always_ff @(posedge i_clk) begin
        r_brk_d[S_BRK]  <= $signed(w_s) > $signed({{18{r_max_stretch[31]}}, r_max_stretch});
        r_sneg_d[S_BRK] <= w_sneg;
        for (int k = S_BRK + 1; k <= S_MAG; k++) r_brk_d[k] <= r_brk_d[k-1];
        for (int k = S_BRK + 1; k < S_MAG; k++) r_sneg_d[k] <= r_sneg_d[k-1];
        r_s2 <= 62'(f_sat_shr(w_p_s2, 16, SAT_LIM));
        r_fm <= 62'(f_sat_shr(w_p_fm, 16, SAT_LIM));
        r_en_d[S_EN] <= 48'(f_sat_shr(w_p_en, 17, SAT_E48));
        for (int k = S_EN + 1; k <= S_MAG; k++) r_en_d[k] <= r_en_d[k-1];
    end

    // Force base floor(fm * 2^16 / r0). The upper quotient bits are zero unless
    // fm / r0 overflows the limit, which is caught up front.
    always_comb begin
        logic [31:0] t;
        logic [31:0] d;
        logic [31:0] diff;
        for (int k = S_FB0 + 1; k <= S_FB; k++) begin
            t    = {r_fb_rem[k-1], r_fb_qd[k-1][61]};
            d    = {1'b0, r_r0_d[k-1]};
            diff = t - d;
            if (t >= d) begin
                n_fb_rem[k] = diff[30:0];
                n_fb_qd[k]  = {r_fb_qd[k-1][60:0], 1'b1};
            end else begin
                n_fb_rem[k] = t[30:0];
                n_fb_qd[k]  = {r_fb_qd[k-1][60:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fb_qd[S_FB0]  <= {r_fm[45:0], 16'd0};
        r_fb_rem[S_FB0] <= 31'(r_fm[61:46]);
        r_fb_sat[S_FB0] <= {15'd0, r_fm[61:46]} >= r_r0_d[S_FM];
        for (int k = S_FB0 + 1; k <= S_FB; k++) begin
            r_fb_qd[k]  <= n_fb_qd[k];
            r_fb_rem[k] <= n_fb_rem[k];
            r_fb_sat[k] <= r_fb_sat[k-1];
        end
    end

    assign w_fb = r_fb_sat[S_FB] ? SAT_LIM[61:0] : r_fb_qd[S_FB];

    generate
        for (genvar a = 0; a < 3; a++) begin : g_force
            pdbf_mul u_mul_f (
                .i_clk (i_clk),
                .i_a   (64'(w_fb)),
                .i_b   (64'(r_u_d[S_FB][a])),
                .o_p   (w_p_f[a])
            );
        end
    endgenerate

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (r_rz_d[S_MAG]) begin
                w_force[a] = '0;
            end else if (r_neg[a]) begin
                w_force[a] = 48'd0 - r_mag[a];
            end else begin
                w_force[a] = r_mag[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_neg[a] <= (r_sneg_d[S_MAG-1] == r_sgn_d[S_MAG-1][a]);
            r_mag[a] <= 48'(f_sat_shr(w_p_f[a], 16,
                            (r_sneg_d[S_MAG-1] == r_sgn_d[S_MAG-1][a]) ? SAT_NEG47
                                                                         : SAT_POS47));
        end
        r_result.force_x     <= w_force[0];
        r_result.force_y     <= w_force[1];
        r_result.force_z     <= w_force[2];
        r_result.bond_energy <= r_en_d[S_MAG];
        r_result.bond_broken <= r_brk_d[S_MAG];
    end

    assign o_strobe = r_vld[S_OUT];
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_zero_length_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_MAG] && r_rz_d[S_MAG] |=>
            o_result.force_x == '0 && o_result.force_y == '0 && o_result.force_z == '0)
        else $error("Force is not zero for a bond of zero length.");

    a_unit_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_U] && !r_rz_d[S_U] |->
            r_u_qd[S_U][0] <= 17'h10000 && r_u_qd[S_U][1] <= 17'h10000 &&
            r_u_qd[S_U][2] <= 17'h10000)
        else $error("Direction cosine exceeds one.");

    a_inverse_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_INV] |-> r_inv_qd[S_INV][0] != '0 && r_inv_qd[S_INV][1] != '0)
        else $error("Reciprocal volume is zero.");

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_OUT-1] && r_rz_d[S_MAG] == 1'b0 |=> o_strobe)
        else $error("A bond in the last stage produced no result transfer.");
`endif

endmodule

`default_nettype wire

// File: sim/peridynamic_bond_force_tb.sv
// Self-checking testbench for the peridynamic bond force block.
// Random and directed bonds are checked against a fixed-point predictor of the bond.
// Depends on pdbf_pkg and the peridynamic_bond_force RTL.
`default_nettype none

module peridynamic_bond_force_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdbf_pkg::*;

    localparam int unsigned LATENCY = 155;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_bond_in i_bond = '0;
    logic o_strobe;
    t_bond_out o_result;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_BULK_MODULUS;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int unsigned mismatches = 0;
    logic [31:0] bulk_q = BULK_MODULUS_RST;
    logic [31:0] stretch_limit_q = MAX_STRETCH_RST;

    always #6 i_clk = ~i_clk;

    peridynamic_bond_force u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_bond(i_bond), .o_strobe(o_strobe), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("error: %s got %h expected %h", what, got, want);
        mismatches++;
    endtask

    function automatic logic [63:0] mul_sat(input logic [63:0] a, input logic [63:0] b,
                                            input int unsigned sh, input logic [63:0] limit);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        return (p > {64'd0, limit}) ? limit : p[63:0];
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_bond_out bond_response(input t_bond_in b);
        t_bond_out o;
        logic signed [63:0] sp [3];
        logic [63:0] mg [3];
        logic [63:0] rsq, r, r0, vi, vj, invsum, c, w, cw, as, s2, fm, fb, q1, u, mag;
        logic signed [63:0] dr, s;
        logic neg;
        rsq = 0;
        sp[0] = b.sep_x;
        sp[1] = b.sep_y;
        sp[2] = b.sep_z;
        for (int a = 0; a < 3; a++) begin
            mg[a] = sp[a] < 0 ? -sp[a] : sp[a];
            rsq += mg[a] * mg[a];
        end
        r = root64(rsq);
        r0 = (b.rest_length == 0) ? 64'd1 : {33'd0, b.rest_length};
        dr = $signed(r) - $signed(r0);
        s = (dr * 64'sd65536) / $signed(r0);
        as = s < 0 ? -s : s;
        vi = (b.inter_volume_i == 0) ? 64'd1 : {32'd0, b.inter_volume_i};
        vj = (b.inter_volume_j == 0) ? 64'd1 : {32'd0, b.inter_volume_j};
        invsum = (64'h1_0000_0000 / vi) + (64'h1_0000_0000 / vj);
        c = mul_sat(64'd9 * bulk_q, invsum, 16, SAT_LIM);
        w = ({32'd0, b.vol_fraction_i} * {32'd0, b.vol_fraction_j}) >> 16;
        cw = mul_sat(c, w, 16, SAT_LIM);
        s2 = mul_sat(as, as, 16, SAT_LIM);
        o.bond_energy = mul_sat(cw, s2, 17, SAT_E48);
        o.bond_broken = s > $signed({{32{stretch_limit_q[31]}}, stretch_limit_q});
        fm = mul_sat(cw, as, 16, SAT_LIM);
        q1 = fm / r0;
        fb = (q1 > (SAT_LIM >> 16)) ? SAT_LIM : (q1 << 16) + (((fm % r0) << 16) / r0);
        for (int a = 0; a < 3; a++) begin
            if (r == 0) begin
                mag = 0;
            end else begin
                u = (mg[a] << 16) / r;
                neg = (s < 0) == (sp[a] < 0);
                mag = mul_sat(fb, u, 16, neg ? SAT_NEG47 : SAT_POS47);
                if (neg) mag = -mag;
            end
            case (a)
                0: o.force_x = mag[47:0];
                1: o.force_y = mag[47:0];
                default: o.force_z = mag[47:0];
            endcase
        end
        return o;
    endfunction

    class bond_scoreboard;
        t_bond_out pending[$];

        function void note_bond(input t_bond_in b);
            pending.push_back(bond_response(b));
        endfunction

        task check_result(input t_bond_out got);
            t_bond_out want;
            if (pending.size() == 0) begin
                report("unexpected result", got.bond_energy, 0);
                return;
            end
            want = pending.pop_front();
            if (got.force_x !== want.force_x) report("force_x", got.force_x, want.force_x);
            if (got.force_y !== want.force_y) report("force_y", got.force_y, want.force_y);
            if (got.force_z !== want.force_z) report("force_z", got.force_z, want.force_z);
            if (got.bond_energy !== want.bond_energy)
                report("bond_energy", got.bond_energy, want.bond_energy);
            if (got.bond_broken !== want.bond_broken)
                report("bond_broken", got.bond_broken, want.bond_broken);
        endtask
    endclass

    bond_scoreboard sb = new();

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_result);
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BULK_MODULUS) bulk_q = val;
        else stretch_limit_q = val;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic send_bond(input t_bond_in b);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
              ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_bond <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_bond(b);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 32'h0004_0000);
            3: return -$urandom_range(0, 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_bond_in rand_bond();
        t_bond_in b;
        b.sep_x = rand_word();
        b.sep_y = rand_word();
        b.sep_z = rand_word();
        b.rest_length = ($urandom_range(0, 2) == 0) ? 31'(rand_word()) :
                        31'($urandom_range(1, 32'h0003_0000));
        b.inter_volume_i = rand_word();
        b.inter_volume_j = rand_word();
        b.vol_fraction_i = ($urandom_range(0, 1) == 0) ? rand_word() : $urandom_range(0, 32'h0002_0000);
        b.vol_fraction_j = ($urandom_range(0, 1) == 0) ? rand_word() : $urandom_range(0, 32'h0002_0000);
        return b;
    endfunction

    task automatic run_phase(input int n);
        for (int k = 0; k < n; k++) send_bond(rand_bond());
        start <= 1'b0;
        drain();
    endtask

    initial begin
        t_bond_in b;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        b = '{sep_x: 32'sh0001_0000, sep_y: 0, sep_z: 0, rest_length: 31'h0001_0000,
              inter_volume_i: 32'h0001_0000, inter_volume_j: 32'h0001_0000,
              vol_fraction_i: 32'h0001_0000, vol_fraction_j: 32'h0001_0000};
        send_bond(b);
        b.sep_x = 32'sh0002_0000;
        send_bond(b);
        b.sep_x = 0;
        send_bond(b);
        b.sep_y = -32'sh0000_8000;
        send_bond(b);
        b.sep_z = 32'sh0001_8000;
        send_bond(b);
        b = '{sep_x: 32'sh7FFF_FFFF, sep_y: 32'sh8000_0000, sep_z: 32'sh7FFF_FFFF,
              rest_length: 0, inter_volume_i: 0, inter_volume_j: 0,
              vol_fraction_i: 32'hFFFF_FFFF, vol_fraction_j: 32'hFFFF_FFFF};
        send_bond(b);
        b.rest_length = 31'h7FFF_FFFF;
        b.inter_volume_i = 32'hFFFF_FFFF;
        b.inter_volume_j = 32'hFFFF_FFFF;
        send_bond(b);
        b.sep_x = 32'sh8000_0000;
        b.sep_z = 32'sh8000_0000;
        b.vol_fraction_i = 0;
        send_bond(b);
        b = '{sep_x: -32'sh0003_0000, sep_y: 32'sh0004_0000, sep_z: 0, rest_length: 31'h0005_0000,
              inter_volume_i: 32'h0000_0001, inter_volume_j: 32'h0002_0000,
              vol_fraction_i: 32'h0000_8000, vol_fraction_j: 32'h0003_0000};
        send_bond(b);
        b.rest_length = 31'h0000_0001;
        send_bond(b);
        start <= 1'b0;
        drain();

        run_phase(150);
        write_reg(CFG_BULK_MODULUS, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_STRETCH, 32'h8000_0000);
        run_phase(120);
        write_reg(CFG_BULK_MODULUS, 0);
        write_reg(CFG_MAX_STRETCH, 32'h7FFF_FFFF);
        run_phase(80);
        write_reg(CFG_BULK_MODULUS, $urandom);
        write_reg(CFG_MAX_STRETCH, 0);
        run_phase(150);

        if (mismatches == 0) begin
            $display("peridynamic_bond_force: match");
        end else begin
            $display("peridynamic_bond_force: mismatch");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("peridynamic_bond_force: mismatch");
        $finish;
    end
endmodule

`default_nettype wire
